// File: src/bgst_pkg.sv
// bgst_pkg: shared types, constants and saturation helpers of the band gap and span tracker
// no dependencies; used by every module under src
package bgst_pkg;

    localparam int ENERGY_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int SPAN_W   = 31;

    typedef logic signed [ENERGY_W-1:0] energy_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;
    typedef logic [SPAN_W-1:0]          span_t;

    localparam energy_t E_MAX          = energy_t'(32'h7FFF_FFFF);
    localparam energy_t E_MIN          = energy_t'(32'h8000_0000);
    localparam weight_t THRESH_RESET   = weight_t'(16'd16384);
    localparam span_t   SPAN_MAX       = span_t'(31'h7FFF_FFFF);
    localparam span_t   SPAN_ZERO      = span_t'(31'd0);

    typedef struct packed {
        energy_t band_energy;
        weight_t band_weight;
        logic    last_band;
        logic    last_item;
    } band_item_t;

    // per-item view of the row state, values as left by this item
    typedef struct packed {
        logic    row_start;
        logic    end_row;
        logic    done;
        energy_t energy;
        logic    has_occ;
        energy_t occ_energy;
        logic    has_empty;
        energy_t empty_energy;
    } row_event_t;

    typedef struct packed {
        energy_t top_occupied;
        energy_t bottom_empty;
        energy_t lowest_first;
        energy_t highest_last;
        logic    any_occ;
        logic    any_empty;
    } run_summary_t;

    function automatic energy_t sat_gap(input energy_t bottom, input energy_t top);
        logic signed [ENERGY_W:0] diff;
        diff = {bottom[ENERGY_W-1], bottom} - {top[ENERGY_W-1], top};
        if (diff[ENERGY_W] != diff[ENERGY_W-1])
        begin
            return diff[ENERGY_W] ? E_MIN : E_MAX;
        end
        return diff[ENERGY_W-1:0];
    endfunction

    function automatic span_t sat_span(input energy_t high, input energy_t low);
        logic signed [ENERGY_W:0] diff;
        diff = {high[ENERGY_W-1], high} - {low[ENERGY_W-1], low};
        if (diff[ENERGY_W])
        begin
            return SPAN_ZERO;
        end
        if (diff[ENERGY_W-1])
        begin
            return SPAN_MAX;
        end
        return diff[SPAN_W-1:0];
    endfunction

endpackage

// File: src/bgst_row_tracker.sv
// bgst_row_tracker: threshold register and per-row homo/lumo candidate state
// depends on bgst_pkg
module bgst_row_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  bgst_pkg::weight_t     cfg_wdata,
    input  logic                  item_fire,
    input  bgst_pkg::band_item_t  item,
    output bgst_pkg::row_event_t  row_event
);

    bgst_pkg::weight_t thresh_reg;
    logic              row_first_reg;
    logic              row_has_occ_reg;
    logic              prev_was_occ_reg;
    logic              row_has_empty_reg;
    bgst_pkg::energy_t row_occ_energy_reg;
    bgst_pkg::energy_t row_empty_energy_reg;

    logic              occ;
    logic              takes_empty;
    logic              end_row;
    logic              row_has_occ_next;
    logic              row_has_empty_next;
    bgst_pkg::energy_t row_occ_energy_next;
    bgst_pkg::energy_t row_empty_energy_next;

    always_comb
    begin
        occ                   = item.band_weight >= thresh_reg;
        takes_empty           = !occ && (prev_was_occ_reg || row_first_reg);
        end_row               = item.last_band || item.last_item;
        row_has_occ_next      = occ || row_has_occ_reg;
        row_occ_energy_next   = occ ? item.band_energy : row_occ_energy_reg;
        row_has_empty_next    = occ ? 1'b0 : (takes_empty || row_has_empty_reg);
        row_empty_energy_next = takes_empty ? item.band_energy : row_empty_energy_reg;

        row_event.row_start    = row_first_reg;
        row_event.end_row      = end_row;
        row_event.done         = item.last_item;
        row_event.energy       = item.band_energy;
        row_event.has_occ      = row_has_occ_next;
        row_event.occ_energy   = row_occ_energy_next;
        row_event.has_empty    = row_has_empty_next;
        row_event.empty_energy = row_empty_energy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg           <= bgst_pkg::THRESH_RESET;
            row_first_reg        <= 1'b1;
            row_has_occ_reg      <= 1'b0;
            prev_was_occ_reg     <= 1'b0;
            row_has_empty_reg    <= 1'b0;
            row_occ_energy_reg   <= '0;
            row_empty_energy_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            if (item_fire)
            begin
                if (end_row)
                begin
                    row_first_reg        <= 1'b1;
                    row_has_occ_reg      <= 1'b0;
                    prev_was_occ_reg     <= 1'b0;
                    row_has_empty_reg    <= 1'b0;
                    row_occ_energy_reg   <= '0;
                    row_empty_energy_reg <= '0;
                end
                else
                begin
                    row_first_reg        <= 1'b0;
                    row_has_occ_reg      <= row_has_occ_next;
                    prev_was_occ_reg     <= occ;
                    row_has_empty_reg    <= row_has_empty_next;
                    row_occ_energy_reg   <= row_occ_energy_next;
                    row_empty_energy_reg <= row_empty_energy_next;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_row_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        row_first_reg |-> (!row_has_occ_reg && !prev_was_occ_reg && !row_has_empty_reg))
        else $error("row starts with stale row state");
`endif

endmodule

// File: src/bgst_run_accum.sv
// bgst_run_accum: run-wide extremes of occupied, empty, first and last band energies
// depends on bgst_pkg; fed by bgst_row_tracker
module bgst_run_accum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_fire,
    input  bgst_pkg::row_event_t    row_event,
    output bgst_pkg::run_summary_t  summary
);

    bgst_pkg::run_summary_t acc_reg;
    bgst_pkg::run_summary_t acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (row_event.row_start && (row_event.energy < acc_reg.lowest_first))
        begin
            acc_next.lowest_first = row_event.energy;
        end
        if (row_event.end_row)
        begin
            if (row_event.energy > acc_reg.highest_last)
            begin
                acc_next.highest_last = row_event.energy;
            end
            if (row_event.has_occ)
            begin
                acc_next.any_occ = 1'b1;
                if (row_event.occ_energy > acc_reg.top_occupied)
                begin
                    acc_next.top_occupied = row_event.occ_energy;
                end
            end
            if (row_event.has_empty)
            begin
                acc_next.any_empty = 1'b1;
                if (row_event.empty_energy < acc_reg.bottom_empty)
                begin
                    acc_next.bottom_empty = row_event.empty_energy;
                end
            end
        end
        summary = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg.top_occupied <= bgst_pkg::E_MIN;
            acc_reg.bottom_empty <= bgst_pkg::E_MAX;
            acc_reg.lowest_first <= bgst_pkg::E_MAX;
            acc_reg.highest_last <= bgst_pkg::E_MIN;
            acc_reg.any_occ      <= 1'b0;
            acc_reg.any_empty    <= 1'b0;
        end
        else if (item_fire)
        begin
            if (row_event.done)
            begin
                acc_reg.top_occupied <= bgst_pkg::E_MIN;
                acc_reg.bottom_empty <= bgst_pkg::E_MAX;
                acc_reg.lowest_first <= bgst_pkg::E_MAX;
                acc_reg.highest_last <= bgst_pkg::E_MIN;
                acc_reg.any_occ      <= 1'b0;
                acc_reg.any_empty    <= 1'b0;
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_occ_top_min: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg.any_occ |-> (acc_reg.top_occupied == bgst_pkg::E_MIN))
        else $error("top occupied moved without an occupied band");
    a_no_empty_bottom_max: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg.any_empty |-> (acc_reg.bottom_empty == bgst_pkg::E_MAX))
        else $error("bottom empty moved without an empty band");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && row_event.done) |=> (!acc_reg.any_occ && !acc_reg.any_empty))
        else $error("run state not cleared after last item");
`endif

endmodule

// File: src/bgst_result.sv
// bgst_result: run summary holding stage, gap and span saturation, output register
// depends on bgst_pkg; fed by bgst_run_accum
module bgst_result (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    snap_load,
    input  bgst_pkg::run_summary_t  summary,
    output logic                    snap_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bgst_pkg::energy_t       band_gap,
    output bgst_pkg::span_t         energy_span,
    output logic                    found_occupied,
    output logic                    found_empty
);

    logic                   snap_valid_reg;
    bgst_pkg::run_summary_t snap_reg;
    logic                   out_valid_reg;
    bgst_pkg::energy_t      gap_reg;
    bgst_pkg::span_t        span_reg;
    logic                   found_occ_reg;
    logic                   found_empty_reg;

    logic                   out_free;
    logic                   snap_valid_next;
    logic                   out_valid_next;

    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        snap_ready      = !snap_valid_reg || out_free;
        snap_valid_next = snap_load ? 1'b1 : (out_free ? 1'b0 : snap_valid_reg);
        out_valid_next  = out_free ? snap_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg <= summary;
        end
        if (out_free && snap_valid_reg)
        begin
            gap_reg         <= bgst_pkg::sat_gap(snap_reg.bottom_empty, snap_reg.top_occupied);
            span_reg        <= bgst_pkg::sat_span(snap_reg.highest_last, snap_reg.lowest_first);
            found_occ_reg   <= snap_reg.any_occ;
            found_empty_reg <= snap_reg.any_empty;
        end
    end

    assign out_valid      = out_valid_reg;
    assign band_gap       = gap_reg;
    assign energy_span    = span_reg;
    assign found_occupied = found_occ_reg;
    assign found_empty    = found_empty_reg;

`ifndef SYNTHESIS
    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !out_free) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("held run summary lost or changed");
`endif

endmodule

// File: src/band_gap_and_span_tracker_unit.sv
// band_gap_and_span_tracker_unit: top level, input register and stream ports
// depends on bgst_pkg, bgst_row_tracker, bgst_run_accum, bgst_result
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata band_energy, band_weight; tlast last_item;
//                                   tuser last_band
// m_*       out  m_tvalid/m_tready  tdata band_gap, energy_span; tuser found flags
// cfg_*     in   cfg_we             cfg_wdata occupied_threshold
//
// one band item per cycle sustained while s_tready stays high; input register, then row and run update
// one result per last item, carried through the input, summary and output registers
// m_tready low holds the result; the summary stage behind it keeps one more
// run, after which a last item waits in the input register and s_tready drops
// rst_n clears all control state and sets the threshold to 1.0
module band_gap_and_span_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // band_energy[31:0], band_weight[47:32]
    input  logic        s_tlast,
    input  logic        s_tuser,   // last_band
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // band_gap[31:0], energy_span[62:32], zero[63]
    output logic [1:0]  m_tuser,   // found_occupied[0], found_empty[1]
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic                   in_valid_reg;
    bgst_pkg::band_item_t   in_item_reg;
    logic                   in_valid_next;
    logic                   in_accept;
    logic                   in_fire;
    logic                   snap_ready;
    bgst_pkg::row_event_t   row_event;
    bgst_pkg::run_summary_t summary;
    bgst_pkg::energy_t      band_gap;
    bgst_pkg::span_t        energy_span;
    logic                   found_occupied;
    logic                   found_empty;

    always_comb
    begin
        in_fire       = in_valid_reg && (!in_item_reg.last_item || snap_ready);
        s_tready      = !in_valid_reg || in_fire;
        in_accept     = s_tvalid && s_tready;
        in_valid_next = in_accept ? 1'b1 : (in_fire ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg.band_energy <= s_tdata[31:0];
            in_item_reg.band_weight <= s_tdata[47:32];
            in_item_reg.last_band   <= s_tuser;
            in_item_reg.last_item   <= s_tlast;
        end
    end

    bgst_row_tracker u_row_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_fire (in_fire),
        .item      (in_item_reg),
        .row_event (row_event)
    );

    bgst_run_accum u_run_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_fire (in_fire),
        .row_event (row_event),
        .summary   (summary)
    );

    bgst_result u_result (
        .clk            (clk),
        .rst_n          (rst_n),
        .snap_load      (in_fire && in_item_reg.last_item),
        .summary        (summary),
        .snap_ready     (snap_ready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .band_gap       (band_gap),
        .energy_span    (energy_span),
        .found_occupied (found_occupied),
        .found_empty    (found_empty)
    );

    assign m_tdata = {1'b0, energy_span, band_gap};
    assign m_tuser = {found_empty, found_occupied};

endmodule

// File: test/band_gap_and_span_tracker_unit_checker.sv
// band gap and span tracker checker: watches the band, result and threshold channels,
// predicts each run result and compares it field by field; depends on bgst_pkg
module band_gap_and_span_tracker_unit_checker
    import bgst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        energy_t gap;
        span_t   span;
        logic    found_occ;
        logic    found_empty;
    } run_result_t;

    run_result_t expected_results[$];

    weight_t threshold;
    logic    at_row_start;
    logic    row_occ_seen;
    logic    last_was_occ;
    logic    row_empty_seen;
    logic    seen_occ;
    logic    seen_empty;
    energy_t row_top_occ;
    energy_t row_bottom_empty;
    energy_t max_occupied;
    energy_t min_empty;
    energy_t min_first;
    energy_t max_last;

    task automatic clear_row();
        at_row_start     = 1'b1;
        row_top_occ      = '0;
        row_occ_seen     = 1'b0;
        last_was_occ     = 1'b0;
        row_bottom_empty = '0;
        row_empty_seen   = 1'b0;
    endtask

    task automatic clear_run();
        clear_row();
        max_occupied = E_MIN;
        min_empty    = E_MAX;
        min_first    = E_MAX;
        max_last     = E_MIN;
        seen_occ     = 1'b0;
        seen_empty   = 1'b0;
    endtask

    task automatic track_band(input energy_t e, input weight_t w, input logic lb,
                              input logic li);
        logic        occ;
        longint      gap;
        longint      span;
        run_result_t res;
        occ = (w >= threshold);
        if (at_row_start && e < min_first)
        begin
            min_first = e;
        end
        if (occ)
        begin
            row_top_occ    = e;
            row_occ_seen   = 1'b1;
            row_empty_seen = 1'b0;
            last_was_occ   = 1'b1;
        end
        else
        begin
            if (last_was_occ || (at_row_start && !row_occ_seen))
            begin
                row_bottom_empty = e;
                row_empty_seen   = 1'b1;
            end
            last_was_occ = 1'b0;
        end
        at_row_start = 1'b0;
        if (lb || li)
        begin
            if (e > max_last)
            begin
                max_last = e;
            end
            if (row_occ_seen)
            begin
                if (row_top_occ > max_occupied)
                begin
                    max_occupied = row_top_occ;
                end
                seen_occ = 1'b1;
            end
            if (row_empty_seen)
            begin
                if (row_bottom_empty < min_empty)
                begin
                    min_empty = row_bottom_empty;
                end
                seen_empty = 1'b1;
            end
            clear_row();
        end
        if (li)
        begin
            gap  = longint'(min_empty) - longint'(max_occupied);
            span = longint'(max_last) - longint'(min_first);
            if (gap > longint'(E_MAX))
            begin
                gap = longint'(E_MAX);
            end
            if (gap < longint'(E_MIN))
            begin
                gap = longint'(E_MIN);
            end
            if (span > longint'(E_MAX))
            begin
                span = longint'(E_MAX);
            end
            if (span < 0)
            begin
                span = 0;
            end
            res.gap         = energy_t'(gap[31:0]);
            res.span        = span_t'(span[30:0]);
            res.found_occ   = seen_occ;
            res.found_empty = seen_empty;
            expected_results.push_back(res);
            clear_run();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        run_result_t want;
        if (!rst_n)
        begin
            threshold = THRESH_RESET;
            clear_run();
            expected_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold = cfg_wdata;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result tdata %h tuser %b", $time, m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.gap)
                    begin
                        $display("%0t: band_gap expected %h actual %h",
                                 $time, want.gap, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[62:32] !== want.span)
                    begin
                        $display("%0t: energy_span expected %h actual %h",
                                 $time, want.span, m_tdata[62:32]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.found_occ)
                    begin
                        $display("%0t: found_occupied expected %b actual %b",
                                 $time, want.found_occ, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.found_empty)
                    begin
                        $display("%0t: found_empty expected %b actual %b",
                                 $time, want.found_empty, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                track_band(s_tdata[31:0], s_tdata[47:32], s_tuser, s_tlast);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// File: test/band_gap_and_span_tracker_unit_tb.sv
// band gap and span tracker testbench top: clock, reset, band stimulus and threshold writes
// depends on bgst_pkg, band_gap_and_span_tracker_unit and band_gap_and_span_tracker_unit_checker
module band_gap_and_span_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgst_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 142;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // band_energy[31:0], band_weight[47:32]
    logic        s_tlast;   // last_item
    logic        s_tuser;   // last_band
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // band_gap[31:0], energy_span[62:32]
    logic [1:0]  m_tuser;   // found_occupied[0], found_empty[1]
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int      fail_count;
    int      outstanding;
    int      cycle_count;
    int      items_sent;
    logic    steady;
    weight_t cur_threshold;

    band_gap_and_span_tracker_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    band_gap_and_span_tracker_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL band_gap_and_span_tracker_unit");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
    end

    task automatic send_band(input energy_t e, input weight_t w, input logic lb,
                             input logic li);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, e};
        s_tuser  <= lb;
        s_tlast  <= li;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_threshold(input weight_t v);
        settle();
        @(negedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= v;
        cur_threshold = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic energy_t rand_energy();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
        begin
            return E_MIN;
        end
        if (roll == 1)
        begin
            return E_MAX;
        end
        return energy_t'($urandom);
    endfunction

    function automatic weight_t occ_weight();
        return weight_t'($urandom_range(65535, cur_threshold));
    endfunction

    function automatic weight_t empty_weight();
        if (cur_threshold == 0)
        begin
            return '0;
        end
        return weight_t'($urandom_range(cur_threshold - 1, 0));
    endfunction

    // mostly ordered rows with an occupied prefix; otherwise noise
    task automatic random_run(input bit well_formed);
        int      rows;
        int      bands;
        int      occ_n;
        int      base;
        int      step;
        bit      wide;
        energy_t e;
        weight_t w;
        logic    lb;
        logic    li;
        rows = $urandom_range(4, 1);
        for (int r = 0; r < rows; r++)
        begin
            bands = $urandom_range(6, 1);
            occ_n = $urandom_range(bands, 0);
            base  = int'($urandom_range(32'h2000_0000, 0)) - 32'sh1000_0000;
            step  = $urandom_range(32'h0010_0000, 0);
            wide  = ($urandom_range(7) == 0);
            for (int b = 0; b < bands; b++)
            begin
                li = (r == rows - 1) && (b == bands - 1);
                if (well_formed)
                begin
                    e  = wide ? rand_energy() : energy_t'(base + b * step);
                    w  = (b < occ_n) ? occ_weight() : empty_weight();
                    lb = (b == bands - 1);
                    if (li && $urandom_range(9) == 0)
                    begin
                        lb = 1'b0;
                    end
                end
                else
                begin
                    e  = rand_energy();
                    w  = weight_t'($urandom_range(65535, 0));
                    lb = (b == bands - 1) ? ($urandom_range(3) != 0) : ($urandom_range(3) == 0);
                end
                send_band(e, w, lb, li);
            end
        end
    endtask

    initial
    begin
        int target;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        cycle_count   = 0;
        items_sent    = 0;
        steady        = 1'b0;
        cur_threshold = THRESH_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ordinary row, weight exactly at and just under the threshold
        send_band(-32'sd100, 16'd16384, 1'b0, 1'b0);
        send_band(32'sd200, 16'd16383, 1'b1, 1'b0);
        send_band(32'sd50, 16'd65535, 1'b0, 1'b0);
        send_band(32'sd300, 16'd0, 1'b1, 1'b1);
        // every band occupied
        send_band(E_MIN, 16'd65535, 1'b0, 1'b0);
        send_band(E_MAX, 16'd20000, 1'b1, 1'b1);
        // nothing occupied anywhere
        send_band(E_MAX, 16'd0, 1'b1, 1'b0);
        send_band(E_MIN, 16'd1, 1'b1, 1'b1);
        // bands out of order, negative span
        send_band(32'sd1000, 16'd30000, 1'b0, 1'b0);
        send_band(-32'sd1000, 16'd0, 1'b1, 1'b1);
        // last item without last band
        send_band(32'sd5, 16'd16384, 1'b0, 1'b0);
        send_band(32'sd7, 16'd0, 1'b0, 1'b1);
        // occupied, empty, occupied again in one row
        send_band(-32'sd20, 16'd40000, 1'b0, 1'b0);
        send_band(-32'sd10, 16'd100, 1'b0, 1'b0);
        send_band(32'sd10, 16'd50000, 1'b1, 1'b1);
        // gap overflow both ways
        send_band(E_MIN, 16'd65535, 1'b0, 1'b0);
        send_band(E_MAX, 16'd0, 1'b1, 1'b1);
        send_band(E_MIN, 16'd0, 1'b1, 1'b0);
        send_band(E_MAX, 16'd65535, 1'b1, 1'b1);
        write_threshold(16'd0);
        send_band(32'sd1, 16'd0, 1'b0, 1'b0);
        send_band(32'sd2, 16'd0, 1'b1, 1'b1);
        write_threshold(16'd65535);
        send_band(-32'sd3, 16'd65534, 1'b0, 1'b0);
        send_band(32'sd4, 16'd65535, 1'b1, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: write_threshold(weight_t'($urandom_range(65535, 0)));
                1: write_threshold(16'd0);
                2: write_threshold(16'd65535);
                3: write_threshold(THRESH_RESET);
                4: write_threshold(16'd1);
                default: write_threshold(weight_t'($urandom_range(32768, 4096)));
            endcase
            steady = (p == 3);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_run($urandom_range(99) < 75);
            end
        end
        steady = 1'b0;

        settle();
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS band_gap_and_span_tracker_unit");
        end
        else
        begin
            $display("FAIL band_gap_and_span_tracker_unit");
        end
        $finish;
    end

endmodule
